// ----- rtl/sgr_pkg.sv -----
// Shared types, constants and helper functions of the gauge stepper ramp driver.
// Depends on nothing; every other file imports it.
package sgr_pkg;

  // Field widths of the item channels
  localparam int unsigned PosBits     = 12;
  localparam int unsigned VelBits     = 13;
  localparam int unsigned FuncBits    = 2;
  localparam int unsigned CoilCount   = 4;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PhaseBits   = 3;
  localparam int unsigned DelayBits   = 12;

  // Ramp table geometry
  localparam int unsigned RampEntries = 5;
  localparam int unsigned EntryBits   = 12;
  localparam int unsigned RampBits    = RampEntries * EntryBits;
  localparam int unsigned RampIdxBits = (RampEntries > 1) ? $clog2(RampEntries) : 1;

  // Configuration port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 60;

  // Reset values of the configuration registers
  localparam logic [PosBits-1:0]     TotalStepsReset = 12'd945;
  localparam logic [CfgDataBits-1:0] RampThrReset    = 60'd84452802612633620;
  localparam logic [CfgDataBits-1:0] RampDlyReset    = 60'd168939978391145400;
  localparam logic [DelayBits-1:0]   ZeroDelayReset  = 12'd800;

  // Item function codes
  localparam logic [FuncBits-1:0] FuncTick      = 2'd0;
  localparam logic [FuncBits-1:0] FuncSetTarget = 2'd1;
  localparam logic [FuncBits-1:0] FuncZero      = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgTotalSteps = 2'd0,
    CfgRampThr    = 2'd1,
    CfgRampDly    = 2'd2,
    CfgZeroDelay  = 2'd3
  } cfg_idx_e;

  typedef logic [RampEntries-1:0][EntryBits-1:0] ramp_tbl_t;

  // Configuration as seen by the motion core
  typedef struct packed {
    logic [PosBits-1:0]   total_steps;
    ramp_tbl_t            ramp_thr;
    ramp_tbl_t            ramp_dly;
    logic [DelayBits-1:0] zero_delay;
  } sgr_cfg_t;

  // Coil drive bits for each phase of the six-phase sequence
  function automatic logic [CoilCount-1:0] phase_coils(input logic [PhaseBits-1:0] phase);
    logic [CoilCount-1:0] coils;
    case (phase)
      3'd0:    coils = 4'h9;
      3'd1:    coils = 4'h1;
      3'd2:    coils = 4'h7;
      3'd3:    coils = 4'h6;
      3'd4:    coils = 4'hE;
      3'd5:    coils = 4'h8;
      default: coils = 4'h0;
    endcase
    return coils;
  endfunction

endpackage

// ----- rtl/sgr_ifs.sv -----
// Valid/ready channel interfaces of the gauge stepper ramp driver: input items,
// result items and configuration writes. Depends on sgr_pkg.

interface sgr_in_if;
  import sgr_pkg::*;
  logic                valid;
  logic                ready;
  logic [FuncBits-1:0] func;
  logic [PosBits-1:0]  target_position;

  modport source (output valid, func, target_position, input ready);
  modport sink   (input valid, func, target_position, output ready);
endinterface

interface sgr_out_if;
  import sgr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CoilCount-1:0]      coil_pattern;
  logic [PosBits-1:0]        position;
  logic signed [VelBits-1:0] velocity;
  logic                      stopped;
  logic                      zeroing;

  modport source (output valid, coil_pattern, position, velocity, stopped, zeroing,
                  input ready);
  modport sink   (input valid, coil_pattern, position, velocity, stopped, zeroing,
                  output ready);
endinterface

interface sgr_cfg_if;
  import sgr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/stepper_gauge_ramp_driver.sv -----
// Top level of the gauge stepper ramp driver: configuration registers and
// motion core. Depends on sgr_pkg, sgr_ifs, sgr_cfg_regs and sgr_motion_core.
//
//   channel    dir  payload                                          accepted when
//   in_item_i  in   func, target_position                            valid && ready
//   res_o      out  coil_pattern, position, velocity, stopped, zeroing valid && ready
//   cfg_i      in   index (2 bits), data (60 bits)                   valid && ready
//
// One item is accepted per clock while in_item_i.ready is high; its result goes
// through the input register, then one pass of the state update, into the result
// register, where it can be taken while res_o.ready is high.
// The result register frees the input side: a new item enters while a result waits.
// A stalled result holds; with both registers full, in_item_i.ready drops.
// Reset is asynchronous: needle state clears, configuration returns to defaults.
// Configuration writes are always taken (cfg_i.ready is high).
module stepper_gauge_ramp_driver (
  input  logic      clk_i,
  input  logic      rst_ni,
  sgr_in_if.sink    in_item_i,
  sgr_out_if.source res_o,
  sgr_cfg_if.sink   cfg_i
);
  import sgr_pkg::*;

  sgr_cfg_t cfg;

  sgr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sgr_motion_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_item_i),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/sgr_cfg_regs.sv -----
// Configuration register file: total steps, ramp tables and zeroing delay.
// Depends on sgr_pkg and sgr_cfg_if.
module sgr_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  sgr_cfg_if.sink           cfg_i,
  output sgr_pkg::sgr_cfg_t cfg_o
);
  import sgr_pkg::*;

  logic [PosBits-1:0]   total_steps_q;
  logic [RampBits-1:0]  ramp_thr_q;
  logic [RampBits-1:0]  ramp_dly_q;
  logic [DelayBits-1:0] zero_delay_q;

  // Take every write at once
  assign cfg_i.ready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_steps_q <= TotalStepsReset;
      ramp_thr_q    <= RampThrReset[RampBits-1:0];
      ramp_dly_q    <= RampDlyReset[RampBits-1:0];
      zero_delay_q  <= ZeroDelayReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgTotalSteps: total_steps_q <= cfg_i.data[PosBits-1:0];
        CfgRampThr:    ramp_thr_q    <= cfg_i.data[RampBits-1:0];
        CfgRampDly:    ramp_dly_q    <= cfg_i.data[RampBits-1:0];
        CfgZeroDelay:  zero_delay_q  <= cfg_i.data[DelayBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.total_steps = total_steps_q;
  assign cfg_o.ramp_thr    = ramp_tbl_t'(ramp_thr_q);
  assign cfg_o.ramp_dly    = ramp_tbl_t'(ramp_dly_q);
  assign cfg_o.zero_delay  = zero_delay_q;

endmodule

// ----- rtl/sgr_delay_lookup.sv -----
// Ramp delay lookup: picks the delay of the first entry whose threshold
// covers the velocity magnitude, else the last entry. Depends on sgr_pkg.
module sgr_delay_lookup (
  input  logic [sgr_pkg::PosBits-1:0]   mag_i,
  input  sgr_pkg::ramp_tbl_t            thr_i,
  input  sgr_pkg::ramp_tbl_t            dly_i,
  output logic [sgr_pkg::DelayBits-1:0] delay_o
);
  import sgr_pkg::*;

  logic [RampIdxBits-1:0] sel;

  // Compare every threshold but the last in parallel, lowest matching entry wins
  always_comb begin
    sel = RampIdxBits'(RampEntries - 1);
    for (int i = RampEntries - 2; i >= 0; i--) begin
      if (thr_i[i] >= mag_i) begin
        sel = RampIdxBits'(i);
      end
    end
  end

  assign delay_o = dly_i[sel];

endmodule

// ----- rtl/sgr_motion_core.sv -----
// Motion core: input register, needle state update and result register.
// Depends on sgr_pkg, sgr_ifs and sgr_delay_lookup.
module sgr_motion_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgr_pkg::sgr_cfg_t cfg_i,
  sgr_in_if.sink            in_i,
  sgr_out_if.source         res_o
);
  import sgr_pkg::*;

  // Input register
  logic                in_valid_q;
  logic [FuncBits-1:0] in_func_q;
  logic [PosBits-1:0]  in_tgt_q;

  // Needle state
  logic [PosBits-1:0]        pos_q, pos_d;
  logic [PosBits-1:0]        goal_q, goal_d;
  logic signed [VelBits-1:0] vel_q, vel_d;
  logic [PhaseBits-1:0]      phase_q, phase_d;
  logic [DelayBits-1:0]      wait_q, wait_d;
  logic                      zact_q, zact_d;
  logic [PosBits-1:0]        zleft_q, zleft_d;

  // Result register
  logic                      res_valid_q;
  logic [CoilCount-1:0]      res_coil_q;
  logic [PosBits-1:0]        res_pos_q;
  logic signed [VelBits-1:0] res_vel_q;
  logic                      res_stop_q;
  logic                      res_zero_q;

  logic advance;

  // Advance the held item when the result register is free or being drained
  assign advance    = in_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Hold one item in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_func_q <= in_i.func;
      in_tgt_q  <= in_i.target_position;
    end
  end

  // Step helpers
  logic                      can_up, can_dn;
  logic [PhaseBits-1:0]      phase_up, phase_dn;
  logic [PosBits-1:0]        last_idx, tgt_clamp;
  logic [DelayBits-1:0]      wait_dec, ramp_delay;
  logic signed [PosBits+2:0] travel, gap;
  logic signed [VelBits-1:0] limit, vel_mv, mag_w;
  logic [PosBits-1:0]        mag;

  assign can_up   = pos_q < cfg_i.total_steps;
  assign can_dn   = pos_q != '0;
  assign phase_up = (phase_q == PhaseBits'(PhaseCount - 1)) ? '0 : phase_q + 3'd1;
  assign phase_dn = (phase_q == '0) ? PhaseBits'(PhaseCount - 1) : phase_q - 3'd1;
  assign last_idx = (cfg_i.total_steps == '0) ? '0 : cfg_i.total_steps - 12'd1;
  assign tgt_clamp = (in_tgt_q > last_idx) ? last_idx : in_tgt_q;
  assign wait_dec = (wait_q != '0) ? wait_q - 12'd1 : '0;

  // Ramp the velocity one unit toward the remaining distance
  assign limit  = $signed({1'b0, cfg_i.ramp_thr[RampEntries-1]});
  assign travel = $signed({3'b000, goal_q}) - $signed({3'b000, pos_q});
  assign gap    = travel - $signed({{2{vel_q[VelBits-1]}}, vel_q});

  always_comb begin
    vel_mv = vel_q;
    if (gap > 0 && vel_q < limit) begin
      vel_mv = vel_q + 13'sd1;
    end else if (gap < 0 && vel_q > -limit) begin
      vel_mv = vel_q - 13'sd1;
    end
  end

  assign mag_w = vel_mv[VelBits-1] ? -vel_mv : vel_mv;
  assign mag   = mag_w[PosBits-1:0];

  sgr_delay_lookup u_lookup (
    .mag_i   (mag),
    .thr_i   (cfg_i.ramp_thr),
    .dly_i   (cfg_i.ramp_dly),
    .delay_o (ramp_delay)
  );

  // Next needle state for the held item
  always_comb begin
    pos_d   = pos_q;
    goal_d  = goal_q;
    vel_d   = vel_q;
    phase_d = phase_q;
    wait_d  = wait_q;
    zact_d  = zact_q;
    zleft_d = zleft_q;
    case (in_func_q)
      FuncTick: begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          if (zact_q) begin
            if (zleft_q != '0) begin
              if (can_dn) begin
                pos_d   = pos_q - 12'd1;
                phase_d = phase_dn;
              end
              zleft_d = zleft_q - 12'd1;
              wait_d  = cfg_i.zero_delay;
            end else begin
              pos_d  = '0;
              goal_d = '0;
              vel_d  = '0;
              zact_d = 1'b0;
              wait_d = '0;
            end
          end else if (!(pos_q == goal_q && vel_q == '0)) begin
            vel_d  = vel_mv;
            wait_d = ramp_delay;
            if (vel_mv > 0 && can_up) begin
              pos_d   = pos_q + 12'd1;
              phase_d = phase_up;
            end else if (vel_mv < 0 && can_dn) begin
              pos_d   = pos_q - 12'd1;
              phase_d = phase_dn;
            end
          end
        end
      end
      FuncSetTarget: begin
        if (!zact_q) begin
          goal_d = tgt_clamp;
        end
      end
      FuncZero: begin
        zact_d  = 1'b1;
        pos_d   = last_idx;
        zleft_d = cfg_i.total_steps;
        wait_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Commit the state as the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      goal_q  <= '0;
      vel_q   <= '0;
      phase_q <= '0;
      wait_q  <= '0;
      zact_q  <= 1'b0;
      zleft_q <= '0;
    end else if (advance) begin
      pos_q   <= pos_d;
      goal_q  <= goal_d;
      vel_q   <= vel_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
      zact_q  <= zact_d;
      zleft_q <= zleft_d;
    end
  end

  // Result register valid: drop on drain, set on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_coil_q <= phase_coils(phase_d);
      res_pos_q  <= pos_d;
      res_vel_q  <= vel_d;
      res_stop_q <= (pos_d == goal_d) && (vel_d == '0);
      res_zero_q <= zact_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.coil_pattern = res_coil_q;
  assign res_o.position     = res_pos_q;
  assign res_o.velocity     = res_vel_q;
  assign res_o.stopped      = res_stop_q;
  assign res_o.zeroing      = res_zero_q;

  // Phase stays inside the six-phase sequence
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PhaseBits'(PhaseCount))
    else $error("coil phase out of range");

  // No zeroing steps remain once zeroing has ended
  a_zero_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !zact_q |-> zleft_q == '0)
    else $error("zeroing steps left while not zeroing");

  // Set-target commands leave the goal alone while zeroing
  a_goal_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_func_q == FuncSetTarget && zact_q) |=> $stable(goal_q))
    else $error("goal moved during zeroing");

  // A tick moves the needle by at most one step, or clears it to zero
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_func_q == FuncTick) |=>
      (pos_q == $past(pos_q) || pos_q == $past(pos_q) + 12'd1 ||
       pos_q == $past(pos_q) - 12'd1 || pos_q == '0))
    else $error("needle moved more than one step on a tick");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the gauge stepper ramp driver: drives ticks and commands,
// predicts every result item and compares it field by field.
// Depends on sgr_pkg, sgr_ifs and the stepper_gauge_ramp_driver RTL.
`timescale 1ns / 1ps

module tb_top;
  import sgr_pkg::*;

  // Unused function code: the block only reports its status
  localparam logic [FuncBits-1:0] FuncSpare = 2'd3;
  localparam logic [PhaseCount-1:0][CoilCount-1:0] CoilByPhase =
    {4'h8, 4'hE, 4'h6, 4'h7, 4'h1, 4'h9};
  localparam logic [CfgDataBits-1:0] AllOnes = '1;

  typedef struct {
    logic [FuncBits-1:0] func;
    logic [PosBits-1:0]  target;
  } gauge_item_t;

  typedef struct {
    logic [CoilCount-1:0]      coil_pattern;
    logic [PosBits-1:0]        position;
    logic signed [VelBits-1:0] velocity;
    logic                      stopped;
    logic                      zeroing;
  } gauge_reading_t;

  logic clk_i;
  logic rst_ni;

  sgr_in_if  in_ch();
  sgr_out_if res_ch();
  sgr_cfg_if cfg_ch();

  stepper_gauge_ramp_driver u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_ch),
    .res_o     (res_ch),
    .cfg_i     (cfg_ch)
  );

  gauge_item_t    pending_items[$];
  gauge_reading_t expected_readings[$];
  int             mismatch_count = 0;
  int             idle_pct = 16;
  logic           item_taken = 1'b0;

  // Register copies
  logic [PosBits-1:0]   cfg_total    = TotalStepsReset;
  ramp_tbl_t            cfg_thr      = RampThrReset;
  ramp_tbl_t            cfg_dly      = RampDlyReset;
  logic [DelayBits-1:0] cfg_zero_dly = ZeroDelayReset;

  // Needle state copies
  logic [PosBits-1:0]        needle_pos  = '0;
  logic [PosBits-1:0]        goal_pos    = '0;
  logic signed [VelBits-1:0] ramp_vel    = '0;
  logic [PhaseBits-1:0]      coil_phase  = '0;
  logic [DelayBits-1:0]      wait_left   = '0;
  logic                      zero_run    = 1'b0;
  logic [PosBits-1:0]        zero_left   = '0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Step the needle down one step if it is above zero
  function automatic void needle_down();
    if (needle_pos > 0) begin
      needle_pos = needle_pos - 1'b1;
      coil_phase = (coil_phase == 0) ? PhaseBits'(PhaseCount - 1) : coil_phase - 1'b1;
    end
  endfunction

  // Advance the needle state by one item and return the status it reports
  function automatic gauge_reading_t predict_item(input logic [FuncBits-1:0] fn,
                                                  input logic [PosBits-1:0] tgt);
    gauge_reading_t r;
    int lim, travel, vel, mag, k;
    logic [PosBits-1:0] top;
    top = (cfg_total == 0) ? '0 : cfg_total - 1'b1;
    case (fn)
      FuncTick: begin
        if (wait_left != 0) wait_left = wait_left - 1'b1;
        if (wait_left == 0) begin
          if (zero_run) begin
            if (zero_left != 0) begin
              needle_down();
              zero_left = zero_left - 1'b1;
              wait_left = cfg_zero_dly;
            end else begin
              needle_pos = '0;
              goal_pos   = '0;
              ramp_vel   = '0;
              zero_run   = 1'b0;
            end
          end else if (!(needle_pos == goal_pos && ramp_vel == 0)) begin
            // Ramp velocity one unit toward the remaining distance, within the limit
            lim    = int'(cfg_thr[RampEntries-1]);
            travel = int'(goal_pos) - int'(needle_pos);
            vel    = int'(ramp_vel);
            if (travel - vel > 0 && vel < lim) vel++;
            else if (travel - vel < 0 && vel > -lim) vel--;
            ramp_vel = VelBits'(vel);
            if (vel > 0 && needle_pos < cfg_total) begin
              needle_pos = needle_pos + 1'b1;
              coil_phase = (coil_phase == PhaseCount - 1) ? '0 : coil_phase + 1'b1;
            end else if (vel < 0) begin
              needle_down();
            end
            // First entry whose threshold covers |velocity|, else the last one
            mag = (vel < 0) ? -vel : vel;
            k = 0;
            while (k < RampEntries - 1 && int'(cfg_thr[k]) < mag) k++;
            wait_left = cfg_dly[k];
          end
        end
      end
      FuncSetTarget: begin
        if (!zero_run) goal_pos = (tgt > top) ? top : tgt;
      end
      FuncZero: begin
        zero_run   = 1'b1;
        needle_pos = top;
        zero_left  = cfg_total;
        wait_left  = '0;
      end
      default: ;
    endcase
    r.coil_pattern = CoilByPhase[coil_phase];
    r.position     = needle_pos;
    r.velocity     = ramp_vel;
    r.stopped      = (needle_pos == goal_pos) && (ramp_vel == 0);
    r.zeroing      = zero_run;
    return r;
  endfunction

  // Drive items and result ready at the falling edge
  always @(negedge clk_i) begin : drive_items
    gauge_item_t nxt;
    if (rst_ni && (!in_ch.valid || item_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_items.pop_front();
        in_ch.valid           <= 1'b1;
        in_ch.func            <= nxt.func;
        in_ch.target_position <= nxt.target;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  // Sample handshakes at the rising edge: track registers, predict, check
  always @(posedge clk_i) begin : watch_channels
    gauge_reading_t want;
    if (!rst_ni) begin
      item_taken = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_e'(cfg_ch.index))
          CfgTotalSteps: cfg_total    = cfg_ch.data[PosBits-1:0];
          CfgRampThr:    cfg_thr      = cfg_ch.data[RampBits-1:0];
          CfgRampDly:    cfg_dly      = cfg_ch.data[RampBits-1:0];
          CfgZeroDelay:  cfg_zero_dly = cfg_ch.data[DelayBits-1:0];
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result item with no expectation pending");
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (res_ch.coil_pattern !== want.coil_pattern) begin
            $error("coil_pattern: expected %h, got %h", want.coil_pattern, res_ch.coil_pattern);
            mismatch_count++;
          end
          if (res_ch.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, res_ch.position);
            mismatch_count++;
          end
          if (res_ch.velocity !== want.velocity) begin
            $error("velocity: expected %0d, got %0d", want.velocity, res_ch.velocity);
            mismatch_count++;
          end
          if (res_ch.stopped !== want.stopped) begin
            $error("stopped: expected %b, got %b", want.stopped, res_ch.stopped);
            mismatch_count++;
          end
          if (res_ch.zeroing !== want.zeroing) begin
            $error("zeroing: expected %b, got %b", want.zeroing, res_ch.zeroing);
            mismatch_count++;
          end
        end
      end
      item_taken = in_ch.valid && in_ch.ready;
      if (item_taken)
        expected_readings.push_back(predict_item(in_ch.func, in_ch.target_position));
    end
  end

  task automatic queue_item(input logic [FuncBits-1:0] fn, input logic [PosBits-1:0] tgt);
    gauge_item_t it;
    it.func   = fn;
    it.target = tgt;
    pending_items.push_back(it);
  endtask

  // Mostly ticks after a target, with some zeroing and spare codes mixed in
  task automatic queue_random_items(input int count, input int zero_pct);
    int roll;
    logic [FuncBits-1:0] fn;
    logic [PosBits-1:0] tgt;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < zero_pct) fn = FuncZero;
      else if (roll < zero_pct + 12) fn = FuncSetTarget;
      else if (roll < zero_pct + 16) fn = FuncSpare;
      else fn = FuncTick;
      tgt = $urandom_range(1) ? PosBits'($urandom_range(0, cfg_total + 2))
                              : PosBits'($urandom());
      queue_item(fn, tgt);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic write_setting(input logic [PosBits-1:0] tot, input ramp_tbl_t thr,
                               input ramp_tbl_t dly, input logic [DelayBits-1:0] zd);
    write_reg(CfgTotalSteps, CfgDataBits'(tot));
    write_reg(CfgRampThr, CfgDataBits'(thr));
    write_reg(CfgRampDly, CfgDataBits'(dly));
    write_reg(CfgZeroDelay, CfgDataBits'(zd));
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    repeat (2) @(negedge clk_i);
  endtask

  // Hold until every item is taken and every result has come
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : run_phases
    ramp_tbl_t thr, dly;
    int lvl;
    in_ch.valid           = 1'b0;
    in_ch.func            = FuncTick;
    in_ch.target_position = '0;
    res_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CfgTotalSteps;
    cfg_ch.data           = '0;
    rst_ni                = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting: clamp, first ramp step, zeroing with ignored target, restart
    queue_item(FuncSetTarget, 12'hFFF);
    queue_item(FuncTick, 12'h000);
    queue_item(FuncTick, 12'hFFF);
    queue_item(FuncSpare, 12'h000);
    queue_item(FuncSetTarget, 12'h000);
    queue_item(FuncTick, 12'h000);
    queue_item(FuncSetTarget, 12'd12);
    queue_item(FuncZero, 12'h000);
    queue_item(FuncSetTarget, 12'd5);
    queue_item(FuncTick, 12'h000);
    queue_item(FuncTick, 12'h000);
    queue_item(FuncZero, 12'hFFF);
    queue_item(FuncSpare, 12'hFFF);
    queue_item(FuncTick, 12'h000);
    wait_drained();

    // Single step of travel, zero limit: leftover velocity lies beyond the limit
    write_setting(12'd1, '0, '0, 12'd1);
    queue_random_items(40, 5);
    wait_drained();

    // Zero total steps: zeroing clears at once, target clamps to zero
    thr = {12'd5, 12'd4, 12'd3, 12'd2, 12'd1};
    dly = {12'd0, 12'd1, 12'd2, 12'd1, 12'd0};
    write_setting(12'd0, thr, dly, 12'hFFF);
    queue_item(FuncZero, 12'h000);
    queue_item(FuncTick, 12'h000);
    queue_item(FuncTick, 12'h000);
    queue_item(FuncSetTarget, 12'hFFF);
    queue_random_items(56, 5);
    wait_drained();

    // Full travel, widest limit, no delay, and no idling on either side
    idle_pct = 0;
    write_setting(12'hFFF, AllOnes[RampBits-1:0], '0, 12'd1);
    queue_item(FuncSetTarget, 12'hFFF);
    queue_random_items(120, 0);
    wait_drained();
    idle_pct = 16;

    // Small random settings, short ramps that run out of table
    repeat (4) begin
      lvl = $urandom_range(0, 2);
      for (int e = 0; e < RampEntries; e++) begin
        thr[e] = EntryBits'(lvl);
        dly[e] = EntryBits'($urandom_range(0, 3));
        lvl += $urandom_range(0, 3);
      end
      write_setting(PosBits'($urandom_range(2, 40)), thr, dly,
                    DelayBits'($urandom_range(0, 3)));
      queue_random_items(60, 4);
      wait_drained();
    end

    // Longest delays: after each step, ticks count down the longest wait
    write_setting(12'hFFF, '0, AllOnes[RampBits-1:0], 12'hFFF);
    queue_random_items(40, 3);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      $error("results still expected at end of run: %0d", expected_readings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS stepper_gauge_ramp_driver");
    end else begin
      $display("FAIL stepper_gauge_ramp_driver");
    end
    $finish;
  end

  // Drop a hung run
  initial begin
    #5_000_000;
    $display("FAIL stepper_gauge_ramp_driver");
    $finish;
  end

endmodule
